>>> rtl/load_multiple_expander_macros.svh
`ifndef LOAD_MULTIPLE_EXPANDER_MACROS_SVH
`define LOAD_MULTIPLE_EXPANDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lme_pkg.sv
package lme_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned REG_W   = 4;
    localparam int unsigned LIST_W  = 15;

    localparam logic [REG_W-1:0]  REG_SP    = 4'hd;
    localparam logic [REG_W-1:0]  REG_PC    = 4'hf;
    localparam logic [WORD_W-1:0] WORD_STEP = 32'd4;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_WBACK   = 2'd1,
        KIND_UNPRED  = 2'd2,
        KIND_NOTIMPL = 2'd3
    } kind_t;

    typedef struct packed {
        logic              bad;
        logic              pc;
        logic              wback;
        logic [REG_W-1:0]  rn;
        logic [LIST_W-1:0] list;
    } lme_dec_t;

endpackage

>>> rtl/lme_in_if.sv
interface lme_in_if import lme_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] inst;
    logic [WORD_W-1:0] base_value;
    logic              in_it_block;
    logic              last_in_it_block;

    modport source (output valid, inst, base_value, in_it_block, last_in_it_block,
                    input ready);
    modport sink   (input valid, inst, base_value, in_it_block, last_in_it_block,
                    output ready);
endinterface

>>> rtl/lme_out_if.sv
interface lme_out_if import lme_pkg::*; ();
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [REG_W-1:0]  reg_index;
    logic [WORD_W-1:0] word_value;
    logic              last;

    modport source (output valid, kind, reg_index, word_value, last, input ready);
    modport sink   (input valid, kind, reg_index, word_value, last, output ready);
endinterface

>>> rtl/lme_check.sv
module lme_check import lme_pkg::*; (
    input  logic [WORD_W-1:0] inst,
    input  logic              in_it_block,
    input  logic              last_in_it_block,
    output lme_dec_t          dec
);

    logic [15:0]      regs;
    logic [REG_W-1:0] rn;
    logic             w;
    logic             p;
    logic             m;
    logic             few;
    logic             rn_listed;

    assign p         = inst[15];
    assign m         = inst[14];
    assign rn        = inst[19:16];
    assign w         = inst[21];
    assign regs      = {p, m, 1'b0, inst[12:0]};
    assign few       = (regs & (regs - 16'd1)) == 16'd0;
    assign rn_listed = regs[rn];

    always_comb
    begin
        dec.pc    = p;
        dec.wback = w;
        dec.rn    = rn;
        dec.list  = regs[LIST_W-1:0];
        dec.bad   = (w && (rn == REG_SP)) || (rn == REG_PC) || few || (p && m)
                    || (p && in_it_block && !last_in_it_block) || (w && rn_listed);
    end

endmodule

>>> rtl/load_multiple_expander.sv
// Expands one Thumb-2 LDM (T2) instruction into a stream of result transactions:
// an unpredictable encoding gives one error result; otherwise one load per listed
// register 0..14 in ascending order with addresses base, base+4, ..., closed by a
// PC not-implemented result or a base writeback when those apply, with last set on
// the final result. The register list is scanned one bit per cycle from a shift
// register, so an instruction passes through an acceptance step, a scan step per
// list position up to the highest listed register (at most 15 positions), and a
// closing step for a PC or writeback result; an error result needs only acceptance.
// Output stalls hold the scan. A new instruction is taken after the scan and any
// closing result, when the output register is empty or read in the same cycle.
`include "load_multiple_expander_macros.svh"

module load_multiple_expander import lme_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lme_in_if.sink    req,
    lme_out_if.source rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } state_t;

    state_t            state_reg,  state_next;
    logic [LIST_W-1:0] list_reg,   list_next;
    logic [REG_W-1:0]  idx_reg,    idx_next;
    logic [WORD_W-1:0] addr_reg,   addr_next;
    logic              pc_reg,     pc_next;
    logic              wb_reg,     wb_next;
    logic [REG_W-1:0]  rn_reg,     rn_next;
    logic              valid_reg,  valid_next;
    kind_t             kind_reg,   kind_next;
    logic [REG_W-1:0]  ridx_reg,   ridx_next;
    logic [WORD_W-1:0] word_reg,   word_next;
    logic              last_reg,   last_next;

    lme_dec_t dec;
    logic     out_free;
    logic     emit;
    logic     rest_empty;

    lme_check u_check (
        .inst             (req.inst),
        .in_it_block      (req.in_it_block),
        .last_in_it_block (req.last_in_it_block),
        .dec              (dec)
    );

    assign out_free   = !valid_reg || rsp.ready;
    assign rest_empty = list_reg[LIST_W-1:1] == '0;
    assign req.ready  = (state_reg == ST_IDLE) && out_free;

    assign rsp.valid      = valid_reg;
    assign rsp.kind       = kind_reg;
    assign rsp.reg_index  = ridx_reg;
    assign rsp.word_value = word_reg;
    assign rsp.last       = last_reg;

    always_comb
    begin
        state_next = state_reg;
        list_next  = list_reg;
        idx_next   = idx_reg;
        addr_next  = addr_reg;
        pc_next    = pc_reg;
        wb_next    = wb_reg;
        rn_next    = rn_reg;
        emit       = 1'b0;
        kind_next  = kind_reg;
        ridx_next  = ridx_reg;
        word_next  = word_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && out_free)
                begin
                    if (dec.bad)
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_UNPRED;
                        ridx_next = '0;
                        word_next = '0;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        list_next  = dec.list;
                        idx_next   = '0;
                        addr_next  = req.base_value;
                        pc_next    = dec.pc;
                        wb_next    = dec.wback;
                        rn_next    = dec.rn;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (list_reg[0])
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_LOAD;
                        ridx_next = idx_reg;
                        word_next = addr_reg;
                        last_next = rest_empty && !pc_reg && !wb_reg;
                        addr_next = addr_reg + WORD_STEP;
                    end
                    list_next = list_reg >> 1;
                    idx_next  = idx_reg + 4'd1;
                    if (rest_empty)
                    begin
                        state_next = (pc_reg || wb_reg) ? ST_FINAL : ST_IDLE;
                    end
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = pc_reg ? KIND_NOTIMPL : KIND_WBACK;
                    ridx_next  = pc_reg ? REG_PC : rn_reg;
                    word_next  = pc_reg ? '0 : addr_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        valid_next = emit || (valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
        pc_reg   <= pc_next;
        wb_reg   <= wb_next;
        rn_reg   <= rn_next;
        if (emit)
        begin
            kind_reg <= kind_next;
            ridx_reg <= ridx_next;
            word_reg <= word_next;
            last_reg <= last_next;
        end
    end

    `LME_ASSERT_NOW(a_scan_nonempty, state_reg == ST_SCAN, list_reg != '0, "scan with empty list")
    `LME_ASSERT_NEXT(a_good_enters_scan, req.valid && req.ready && !dec.bad, state_reg == ST_SCAN, "accepted instruction did not start scan")
    `LME_ASSERT_NEXT(a_final_emits_last, state_reg == ST_FINAL && out_free, rsp.valid && rsp.last && state_reg == ST_IDLE, "closing result missing")
    `LME_ASSERT_NOW(a_final_needs_tail, state_reg == ST_FINAL, pc_reg || wb_reg, "closing state without pc or writeback")

endmodule

>>> bench/load_multiple_expander_tb.sv
`timescale 1ns / 100ps

import lme_pkg::*;

typedef struct packed {
    kind_t             kind;
    logic [REG_W-1:0]  reg_index;
    logic [WORD_W-1:0] word_value;
    logic              last;
} ldm_result_t;

function automatic logic [15:0] ldm_register_set(logic [WORD_W-1:0] inst);
    return {inst[15], inst[14], 1'b0, inst[12:0]};
endfunction

function automatic bit ldm_unpredictable(logic [WORD_W-1:0] inst, logic in_it, logic last_it);
    logic [15:0]      regs;
    logic [REG_W-1:0] rn;
    logic             wb;
    regs = ldm_register_set(inst);
    rn   = inst[19:16];
    wb   = inst[21];
    return (wb && rn == REG_SP) || rn == REG_PC || $countones(regs) < 2
        || (inst[15] && inst[14]) || (inst[15] && in_it && !last_it)
        || (wb && regs[rn]);
endfunction

class ldm_result_tracker;
    ldm_result_t pending_results[$];
    int unsigned mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    function int unsigned outstanding();
        return pending_results.size();
    endfunction

    function void note_instruction(logic [WORD_W-1:0] inst, logic [WORD_W-1:0] base,
                                   logic in_it, logic last_it);
        logic [15:0]       regs;
        logic [WORD_W-1:0] addr;
        ldm_result_t       r;
        regs = ldm_register_set(inst);
        if (ldm_unpredictable(inst, in_it, last_it))
        begin
            r = '{kind: KIND_UNPRED, reg_index: '0, word_value: '0, last: 1'b1};
            pending_results.push_back(r);
            return;
        end
        addr = base;
        for (int i = 0; i < LIST_W; i++)
        begin
            if (regs[i])
            begin
                r = '{kind: KIND_LOAD, reg_index: REG_W'(i), word_value: addr, last: 1'b0};
                pending_results.push_back(r);
                addr += WORD_STEP;
            end
        end
        if (inst[15])
        begin
            r = '{kind: KIND_NOTIMPL, reg_index: REG_PC, word_value: '0, last: 1'b1};
            pending_results.push_back(r);
        end
        else if (inst[21])
        begin
            r = '{kind: KIND_WBACK, reg_index: inst[19:16],
                  word_value: base + WORD_STEP * WORD_W'($countones(regs)), last: 1'b1};
            pending_results.push_back(r);
        end
        else
        begin
            pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endfunction

    function void check_result(ldm_result_t got);
        ldm_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected transaction: kind %0d reg %0d word %h last %b",
                         got.kind, got.reg_index, got.word_value, got.last);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.reg_index !== want.reg_index
            || got.word_value !== want.word_value || got.last !== want.last)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display({"mismatch: expected kind %0d reg %0d word %h last %b, ",
                          "got kind %0d reg %0d word %h last %b"},
                         want.kind, want.reg_index, want.word_value, want.last,
                         got.kind, got.reg_index, got.word_value, got.last);
        end
    endfunction
endclass

module load_multiple_expander_tb;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 35;

    logic clk = 1'b0;
    logic rst_n;

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  holdoff_request = 1'b0;

    ldm_result_tracker tracker = new();

    lme_in_if  req_if ();
    lme_out_if rsp_if ();

    load_multiple_expander DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] ldm_word(logic pc, logic lr, logic wb,
                                                   logic [REG_W-1:0] rn, logic [12:0] list);
        return {10'b1110100010, wb, 1'b1, rn, pc, lr, 1'b0, list};
    endfunction

    task automatic send_instruction(logic [WORD_W-1:0] inst, logic [WORD_W-1:0] base,
                                    logic in_it, logic last_it);
        if ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_if.valid            <= 1'b1;
        req_if.inst             <= inst;
        req_if.base_value       <= base;
        req_if.in_it_block      <= in_it;
        req_if.last_in_it_block <= last_it;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        tracker.note_instruction(inst, base, in_it, last_it);
    endtask

    task automatic send_random_instruction();
        logic [WORD_W-1:0] inst;
        logic [WORD_W-1:0] base;
        logic              in_it;
        logic              last_it;
        int                tries;
        bit                well_formed;
        well_formed = ($urandom_range(99) < 80);
        tries = 0;
        do
        begin
            inst    = $urandom;
            in_it   = 1'($urandom_range(1));
            last_it = 1'($urandom_range(1));
            if ($urandom_range(3) == 0)
                inst[12:0] = inst[12:0] & 13'($urandom);
            tries++;
        end
        while (well_formed && tries < 50 && ldm_unpredictable(inst, in_it, last_it));
        case ($urandom_range(3))
            0: base = 32'hffff_ffff - $urandom_range(63);
            1: base = $urandom_range(63);
            default: base = $urandom;
        endcase
        send_instruction(inst, base, in_it, last_it);
    endtask

    // receiver side, with a long hold-off on request
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_request)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES)
                    @(posedge clk);
                holdoff_request = 1'b0;
            end
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            tracker.check_result('{kind: rsp_if.kind, reg_index: rsp_if.reg_index,
                                   word_value: rsp_if.word_value, last: rsp_if.last});
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n                   <= 1'b0;
        req_if.valid            <= 1'b0;
        req_if.inst             <= '0;
        req_if.base_value       <= '0;
        req_if.in_it_block      <= 1'b0;
        req_if.last_in_it_block <= 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unpredictable encodings
        send_instruction(ldm_word(1'b0, 1'b0, 1'b1, REG_SP, 13'h0003), 32'h1000, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b0, REG_PC, 13'h0003), 32'h1000, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b0, 4'd1, 13'h0000), 32'h1000, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b0, 4'd1, 13'h0010), 32'h1000, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b1, 1'b1, 1'b0, 4'd1, 13'h0004), 32'h1000, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b1, 1'b0, 1'b0, 4'd1, 13'h0004), 32'h1000, 1'b1, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b1, 4'd2, 13'h0006), 32'h1000, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b1, 1'b1, 4'd14, 13'h0001), 32'h1000, 1'b0, 1'b0);
        send_instruction(32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
        send_instruction(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        // pc in the list
        send_instruction(ldm_word(1'b1, 1'b0, 1'b0, 4'd3, 13'h1fff), 32'h2000, 1'b1, 1'b1);
        send_instruction(ldm_word(1'b1, 1'b0, 1'b1, 4'd0, 13'h0002), 32'h2000, 1'b0, 1'b1);
        send_instruction(ldm_word(1'b1, 1'b0, 1'b0, 4'd0, 13'h0001), 32'h0, 1'b0, 1'b0);
        // writeback and plain runs
        send_instruction(ldm_word(1'b0, 1'b1, 1'b1, 4'd0, 13'h1ffe), 32'h3000, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b1, 1'b0, 4'd0, 13'h1fff), 32'h3000, 1'b1, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b1, 4'd14, 13'h1fff), 32'hffff_fff8, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b1, 1'b0, 4'd14, 13'h1fff), 32'hffff_fffc, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b0, REG_SP, 13'h0006), 32'h8000_0000, 1'b0, 1'b1);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b0, 4'd5, 13'h0003), 32'hffff_ffff, 1'b0, 1'b0);
        send_instruction(ldm_word(1'b0, 1'b1, 1'b1, 4'd12, 13'h0001), 32'h7fff_fffc, 1'b1, 1'b1);
        send_instruction(ldm_word(1'b0, 1'b0, 1'b1, 4'd12, 13'h0c00), 32'h0000_0010, 1'b0, 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  holdoff_request = 1'b1; end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_random_instruction();
        end
        req_if.valid <= 1'b0;

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);

        if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> load_multiple_expander.f
+incdir+rtl
rtl/lme_pkg.sv
rtl/lme_in_if.sv
rtl/lme_out_if.sv
rtl/lme_check.sv
rtl/load_multiple_expander.sv
bench/load_multiple_expander_tb.sv
